// ===== hw/rtl/sit_pkg.sv =====
`timescale 1ns / 1ps
package sit_pkg;

    localparam int TIME_W       = 31;
    localparam int LEN_W        = 32;
    localparam int CNT_OUT_W    = 7;
    localparam int CAPACITY_DEF = 64;

    // cell operation codes
    localparam logic [1:0] PH_HOLD   = 2'd0;
    localparam logic [1:0] PH_MERGE  = 2'd1;
    localparam logic [1:0] PH_INSERT = 2'd2;
    localparam logic [1:0] PH_ROTATE = 2'd3;

    // register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_SUM_MODE  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
    } entry_t;

    typedef struct packed {
        logic [1:0]        phase;
        logic              second;   // another overlapping entry follows the first
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/sit_cell.sv =====
`timescale 1ns / 1ps
// One table slot. Compares its entry against the new interval and moves
// data from a neighbor as the shared command says.
module sit_cell
(
    input  logic                clk,
    input  sit_pkg::cell_ctrl_t ctrl,
    input  logic                valid,
    input  sit_pkg::entry_t     left,
    input  sit_pkg::entry_t     right,
    input  logic                left_nb,
    input  logic                left_ov,
    output logic                below,
    output logic                ov,
    output sit_pkg::entry_t     q
);

    sit_pkg::entry_t q_reg;
    sit_pkg::entry_t q_next;
    logic            first_ov;

    assign below    = valid && (q_reg.hi < ctrl.s);
    assign ov       = valid && (q_reg.lo <= ctrl.e) && (q_reg.hi >= ctrl.s);
    assign first_ov = ov && !left_ov;
    assign q        = q_reg;

    always_comb
    begin
        q_next = q_reg;
        case (ctrl.phase)
            sit_pkg::PH_MERGE:
            begin
                if (first_ov)
                begin
                    if (ctrl.second)
                        q_next.hi = right.hi;
                    else
                    begin
                        q_next.lo = (ctrl.s < q_reg.lo) ? ctrl.s : q_reg.lo;
                        q_next.hi = (ctrl.e > q_reg.hi) ? ctrl.e : q_reg.hi;
                    end
                end
                else if (left_nb && ctrl.second)
                    q_next = right;
            end
            sit_pkg::PH_INSERT:
            begin
                if (left_nb)
                    q_next = left;
                else if (!below)
                begin
                    q_next.lo = ctrl.s;
                    q_next.hi = ctrl.e;
                end
            end
            sit_pkg::PH_ROTATE:
                q_next = right;
            default:
                q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

// ===== hw/rtl/sorted_interval_union_table_unit.sv =====
`timescale 1ns / 1ps
// Sorted interval union table.
// Holds up to CAPACITY disjoint closed intervals sorted by start, one per cell
// of a chain. An item (clear_first, start_time, end_time) is taken at a clock
// edge with start high and busy low; start_time and end_time may come in
// either order. The item first clears the table if asked, then goes through
// one apply step: either a new entry is shifted in at its sorted place, or it
// merges with the overlapping run, one absorbed entry per cycle. When the
// table is full and nothing overlaps, the item is dropped and overflow is set.
// Then the chain rotates once all the way round while the total length is
// summed and the longest length found from the head cell.
// One item is in work at a time; busy stays high until the result is out.
// done is high for exactly one cycle with the result on the output ports;
// the receiver cannot stall, and no result is held back.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 threshold, 1 sum mode)
// and cfg_data; cfg_ready is always high. Write only while idle.
// Reset empties the table, sets threshold to 1 and sum mode to 0.
module sorted_interval_union_table_unit
#(
    parameter int CAPACITY = sit_pkg::CAPACITY_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           clear_first,
    input  logic [sit_pkg::TIME_W-1:0]     start_time,
    input  logic [sit_pkg::TIME_W-1:0]     end_time,
    output logic                           done,
    output logic [sit_pkg::CNT_OUT_W-1:0]  interval_count,
    output logic [sit_pkg::LEN_W-1:0]      total_length,
    output logic [sit_pkg::LEN_W-1:0]      longest_length,
    output logic                           reached,
    output logic                           overflow,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [sit_pkg::LEN_W-1:0]      cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_APPLY = 2'd1;
    localparam logic [1:0] ST_STATS = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [sit_pkg::TIME_W-1:0]  s_reg, s_next, e_reg, e_next;
    logic [sit_pkg::LEN_W-1:0]   total_reg, total_next, long_reg, long_next;
    logic                        ovf_reg, ovf_next;
    logic [sit_pkg::LEN_W-1:0]   thr_reg;
    logic                        mode_reg;
    logic                        done_reg;
    logic [sit_pkg::CNT_OUT_W-1:0] cnt_out_reg;
    logic [sit_pkg::LEN_W-1:0]   tot_out_reg, long_out_reg;
    logic                        reached_reg, ovf_out_reg;

    sit_pkg::cell_ctrl_t         ctrl;
    sit_pkg::entry_t             q [CAPACITY];
    logic [CAPACITY-1:0]         below_v, ov_v;
    logic                        ov_any, second, full;
    logic [sit_pkg::LEN_W-1:0]   len0, add_len, measure;

    assign ov_any = |ov_v;
    assign second = |(ov_v & {ov_v[CAPACITY-2:0], 1'b0});
    assign full   = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        ctrl.s      = s_reg;
        ctrl.e      = e_reg;
        ctrl.second = second;
        ctrl.phase  = sit_pkg::PH_HOLD;
        if (state_reg == ST_APPLY)
        begin
            if (ov_any)
                ctrl.phase = sit_pkg::PH_MERGE;
            else if (!full)
                ctrl.phase = sit_pkg::PH_INSERT;
        end
        else if (state_reg == ST_STATS)
            ctrl.phase = sit_pkg::PH_ROTATE;
    end

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            sit_cell u_cell
            (
                .clk     (clk),
                .ctrl    (ctrl),
                .valid   (count_reg > CW'(k)),
                .left    ((k == 0) ? q[0] : q[(k + CAPACITY - 1) % CAPACITY]),
                .right   (q[(k + 1) % CAPACITY]),
                .left_nb ((k == 0) ? 1'b0 : !below_v[(k + CAPACITY - 1) % CAPACITY]),
                .left_ov ((k == 0) ? 1'b0 : ov_v[(k + CAPACITY - 1) % CAPACITY]),
                .below   (below_v[k]),
                .ov      (ov_v[k]),
                .q       (q[k])
            );
        end
    endgenerate

    // head cell length during the rotation
    assign len0    = {1'b0, q[0].hi} - {1'b0, q[0].lo} + sit_pkg::LEN_W'(1);
    assign add_len = (CW'(idx_reg) < count_reg) ? len0 : '0;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        s_next     = s_reg;
        e_next     = e_reg;
        total_next = total_reg;
        long_next  = long_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    s_next     = (start_time > end_time) ? end_time : start_time;
                    e_next     = (start_time > end_time) ? start_time : end_time;
                    if (clear_first)
                        count_next = '0;
                    total_next = '0;
                    long_next  = '0;
                    ovf_next   = 1'b0;
                    idx_next   = '0;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (ov_any)
                begin
                    if (second)
                        count_next = count_reg - CW'(1);
                    else
                        state_next = ST_STATS;
                end
                else
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                        count_next = count_reg + CW'(1);
                    state_next = ST_STATS;
                end
            end
            ST_STATS:
            begin
                total_next = total_reg + add_len;
                long_next  = (add_len > long_reg) ? add_len : long_reg;
                idx_next   = idx_reg + IW'(1);
                if (idx_reg == IW'(CAPACITY - 1))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign measure = mode_reg ? total_next : long_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
            thr_reg   <= sit_pkg::LEN_W'(1);
            mode_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
            done_reg  <= (state_reg == ST_STATS) && (state_next == ST_IDLE);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sit_pkg::CFG_THRESHOLD: thr_reg  <= cfg_data;
                    sit_pkg::CFG_SUM_MODE:  mode_reg <= cfg_data[0];
                    default:                thr_reg  <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        e_reg     <= e_next;
        total_reg <= total_next;
        long_reg  <= long_next;
        if ((state_reg == ST_STATS) && (state_next == ST_IDLE))
        begin
            cnt_out_reg  <= sit_pkg::CNT_OUT_W'(count_reg);
            tot_out_reg  <= total_next;
            long_out_reg <= long_next;
            reached_reg  <= (measure >= thr_reg);
            ovf_out_reg  <= ovf_reg;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign interval_count = cnt_out_reg;
    assign total_length   = tot_out_reg;
    assign longest_length = long_out_reg;
    assign reached        = reached_reg;
    assign overflow       = ovf_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("table count above capacity");

    a_done_after_stats: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_STATS))
        else $error("result strobe without a finished rotation");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STATS && ovf_reg) |-> full)
        else $error("overflow with room left");

endmodule
